// ===== hdl/bsbt_pkg.sv =====
// shared constants, operation codes and cell control structs for the stack and bag store
package bsbt_pkg;

  localparam int unsigned DEPTH   = 64;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned IDX_W   = $clog2(DEPTH);
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
  localparam int unsigned KIND_W  = 4;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned ST_W    = 2;
  localparam int unsigned IN_W    = 48;
  localparam int unsigned OUT_W   = 48;

  localparam logic [KIND_W-1:0] KIND_PUSH         = 4'd0;
  localparam logic [KIND_W-1:0] KIND_POP          = 4'd1;
  localparam logic [KIND_W-1:0] KIND_TOP          = 4'd2;
  localparam logic [KIND_W-1:0] KIND_GET          = 4'd3;
  localparam logic [KIND_W-1:0] KIND_PUT          = 4'd4;
  localparam logic [KIND_W-1:0] KIND_SWAP         = 4'd5;
  localparam logic [KIND_W-1:0] KIND_REMOVE_AT    = 4'd6;
  localparam logic [KIND_W-1:0] KIND_CONTAINS     = 4'd7;
  localparam logic [KIND_W-1:0] KIND_REMOVE_VALUE = 4'd8;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd3;

  // read and compare phase, broadcast to every cell
  typedef struct packed {
    logic              cap_en;
    logic [CNT_W-1:0]  cnt;
    logic [IDX_W-1:0]  addr_a;
    logic [IDX_W-1:0]  addr_b;
    logic [DATA_W-1:0] value;
  } bsbt_probe_t;

  // update phase, broadcast to every cell
  typedef struct packed {
    logic              wa_en;
    logic [IDX_W-1:0]  wa_addr;
    logic [DATA_W-1:0] wa_data;
    logic              wb_en;
    logic [IDX_W-1:0]  wb_addr;
    logic [DATA_W-1:0] wb_data;
    logic              shift_en;
    logic              del_by_idx;
    logic [IDX_W-1:0]  del_addr;
  } bsbt_cmd_t;

endpackage

// ===== hdl/bounded_stack_bag_table.sv =====
// top level of the bounded stack and bag store: handshake, status decode and cell chain
//
// A store of 64 entries of 32 bits kept in a chain of cells, used as a stack
// (push, pop, top), as a bag (contains, remove first match) and by position
// (get, put, swap, remove at a position with the later entries moved down).
// Each accepted transaction yields exactly one result. In the accept cycle
// every cell is read and compared against the item in parallel and the
// status is decided; in the update state that follows, all cells update
// at once, and the result enters the output register. The input is
// taken again in the cycle after that, even while the result still waits to
// be taken; only a second result waiting behind a full output register
// stalls the update cycle. A push beyond the capacity limit register
// (clamped to 64) is refused with a full status. The entries have no reset.
module bounded_stack_bag_table import bsbt_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_wr_en_i,
  input  logic [CNT_W-1:0] cfg_wr_data_i,  // capacity_limit
  input  logic             s_tvalid_i,
  output logic             s_tready_o,
  input  logic [IN_W-1:0]  s_tdata_i,      // kind[3:0], index_a[9:4], index_b[15:10], value[47:16]
  output logic             m_tvalid_o,
  input  logic             m_tready_i,
  output logic [OUT_W-1:0] m_tdata_o       // read_value[31:0], found[32], count[39:33], status[41:40]
);

  localparam logic S_IDLE   = 1'b0;
  localparam logic S_COMMIT = 1'b1;

  logic              state_q, state_d;
  logic [CNT_W-1:0]  cap_q;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [KIND_W-1:0] kind_q;
  logic [IDX_W-1:0]  ia_q, ib_q;
  logic [DATA_W-1:0] val_q, rda_q, rdb_q;
  logic [ST_W-1:0]   status_q, status_d;
  logic              m_valid_q;
  logic [OUT_W-1:0]  m_data_q;

  logic [KIND_W-1:0] in_kind;
  logic [IDX_W-1:0]  in_ia, in_ib;
  logic [DATA_W-1:0] in_val;
  logic [CNT_W-1:0]  limit;
  logic              ia_bad, ib_bad;
  logic              s_fire, commit_fire, ok, found;
  logic [DATA_W-1:0] read_value;

  bsbt_probe_t       probe;
  bsbt_cmd_t         cmd;

  logic [DATA_W-1:0] entry  [DEPTH];
  logic [DATA_W-1:0] rd_a   [DEPTH+1];
  logic [DATA_W-1:0] rd_b   [DEPTH+1];
  logic              seen   [DEPTH+1];

  assign in_kind = s_tdata_i[3:0];
  assign in_ia   = s_tdata_i[9:4];
  assign in_ib   = s_tdata_i[15:10];
  assign in_val  = DATA_W'(s_tdata_i[47:16]);

  assign s_tready_o  = (state_q == S_IDLE);
  assign s_fire      = s_tvalid_i && s_tready_o;
  assign commit_fire = (state_q == S_COMMIT) && (!m_valid_q || m_tready_i);

  assign limit  = (cap_q > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : cap_q;
  assign ia_bad = {1'b0, in_ia} >= count_q;
  assign ib_bad = {1'b0, in_ib} >= count_q;

  always_comb begin
    status_d = ST_OK;
    if (in_kind == KIND_PUSH) begin
      if (count_q >= limit) status_d = ST_FULL;
    end else if (in_kind <= KIND_REMOVE_VALUE) begin
      if (count_q == '0) begin
        status_d = ST_EMPTY;
      end else if ((in_kind inside {KIND_GET, KIND_PUT, KIND_REMOVE_AT}) && ia_bad) begin
        status_d = ST_RANGE;
      end else if ((in_kind == KIND_SWAP) && (ia_bad || ib_bad)) begin
        status_d = ST_RANGE;
      end
    end
  end

  always_comb begin
    probe.cap_en = s_fire;
    probe.cnt    = count_q;
    probe.addr_a = (in_kind == KIND_TOP) ? IDX_W'(count_q - CNT_W'(1)) : in_ia;
    probe.addr_b = in_ib;
    probe.value  = in_val;
  end

  assign ok = (status_q == ST_OK);

  always_comb begin
    cmd.wa_en      = commit_fire && ok &&
                     ((kind_q == KIND_PUSH) || (kind_q == KIND_PUT) || (kind_q == KIND_SWAP));
    cmd.wa_addr    = (kind_q == KIND_PUSH) ? count_q[IDX_W-1:0] : ia_q;
    cmd.wa_data    = (kind_q == KIND_SWAP) ? rdb_q : val_q;
    cmd.wb_en      = commit_fire && ok && (kind_q == KIND_SWAP);
    cmd.wb_addr    = ib_q;
    cmd.wb_data    = rda_q;
    cmd.shift_en   = commit_fire && ok &&
                     ((kind_q == KIND_REMOVE_AT) || (kind_q == KIND_REMOVE_VALUE));
    cmd.del_by_idx = (kind_q == KIND_REMOVE_AT);
    cmd.del_addr   = ia_q;
  end

  assign rd_a[0] = '0;
  assign rd_b[0] = '0;
  assign seen[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    bsbt_cell u_cell (
      .clk_i         (clk_i),
      .idx_i         (IDX_W'(i)),
      .probe_i       (probe),
      .cmd_i         (cmd),
      .upper_entry_i (entry[(i + 1 < DEPTH) ? i + 1 : i]),
      .entry_o       (entry[i]),
      .rd_a_i        (rd_a[i]),
      .rd_a_o        (rd_a[i+1]),
      .rd_b_i        (rd_b[i]),
      .rd_b_o        (rd_b[i+1]),
      .seen_i        (seen[i]),
      .seen_o        (seen[i+1])
    );
  end

  assign found = ok && seen[DEPTH] &&
                 ((kind_q == KIND_CONTAINS) || (kind_q == KIND_REMOVE_VALUE));
  assign read_value = (ok && ((kind_q == KIND_TOP) || (kind_q == KIND_GET))) ? rda_q : '0;

  always_comb begin
    count_d = count_q;
    if (ok) begin
      case (kind_q)
        KIND_PUSH:         count_d = count_q + CNT_W'(1);
        KIND_POP:          count_d = count_q - CNT_W'(1);
        KIND_REMOVE_AT:    count_d = count_q - CNT_W'(1);
        KIND_REMOVE_VALUE: if (found) count_d = count_q - CNT_W'(1);
        default:           count_d = count_q;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (s_fire) state_d = S_COMMIT;
      S_COMMIT: if (commit_fire) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cap_q     <= CNT_W'(DEPTH);
      count_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_wr_en_i) cap_q <= cfg_wr_data_i;
      if (commit_fire) begin
        count_q   <= count_d;
        m_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      kind_q   <= in_kind;
      ia_q     <= in_ia;
      ib_q     <= in_ib;
      val_q    <= in_val;
      status_q <= status_d;
      rda_q    <= rd_a[DEPTH];
      rdb_q    <= rd_b[DEPTH];
    end
    if (commit_fire) begin
      m_data_q <= {{(OUT_W - VAL_W - 1 - CNT_W - ST_W){1'b0}}, status_q, count_d, found,
                   VAL_W'(read_value)};
    end
  end

  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = m_data_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("entry count beyond depth");

  a_count_only_on_commit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !commit_fire |=> $stable(count_q))
    else $error("entry count changed outside update cycle");

  a_refused_push_keeps_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit_fire && (status_q == ST_FULL) |=> (count_q == $past(count_q)))
    else $error("refused push changed the count");

  a_commit_gives_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit_fire |=> m_tvalid_o)
    else $error("update cycle without a result");

endmodule

// ===== hdl/bsbt_cell.sv =====
// one storage cell of the chain: holds one entry, reads, compares and shifts down
module bsbt_cell import bsbt_pkg::*; (
  input  logic              clk_i,
  input  logic [IDX_W-1:0]  idx_i,
  input  bsbt_probe_t       probe_i,
  input  bsbt_cmd_t         cmd_i,
  input  logic [DATA_W-1:0] upper_entry_i,
  output logic [DATA_W-1:0] entry_o,
  input  logic [DATA_W-1:0] rd_a_i,
  output logic [DATA_W-1:0] rd_a_o,
  input  logic [DATA_W-1:0] rd_b_i,
  output logic [DATA_W-1:0] rd_b_o,
  input  logic              seen_i,
  output logic              seen_o
);

  logic [DATA_W-1:0] entry_q, entry_d;
  logic              match_q, match_d;
  logic              live;
  logic              mark;

  assign live    = {1'b0, idx_i} < probe_i.cnt;
  assign match_d = live && (entry_q == probe_i.value);
  assign rd_a_o  = rd_a_i | ((idx_i == probe_i.addr_a) ? entry_q : '0);
  assign rd_b_o  = rd_b_i | ((idx_i == probe_i.addr_b) ? entry_q : '0);

  // cells at and above the removed position take the upper neighbor's entry
  assign mark   = cmd_i.del_by_idx ? (idx_i == cmd_i.del_addr) : match_q;
  assign seen_o = seen_i | mark;

  always_comb begin
    entry_d = entry_q;
    if (cmd_i.shift_en && seen_o) begin
      entry_d = upper_entry_i;
    end else if (cmd_i.wa_en && (idx_i == cmd_i.wa_addr)) begin
      entry_d = cmd_i.wa_data;
    end else if (cmd_i.wb_en && (idx_i == cmd_i.wb_addr)) begin
      entry_d = cmd_i.wb_data;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    if (probe_i.cap_en) begin
      match_q <= match_d;
    end
  end

  assign entry_o = entry_q;

endmodule
